// ===== hw/rtl/stsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types and constants of the sine table sample core: register
// indexes, fixed field widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package stsc_pkg;

  localparam int unsigned CntW   = 13;  // sample_count width
  localparam int unsigned LvlW   = 12;  // level and index width
  localparam int unsigned IdxW   = 2;   // configuration register index width
  localparam int unsigned CfgW   = 13;  // configuration data width
  localparam int unsigned FracW  = 22;  // Q2.22 fraction bits
  localparam int unsigned XyW    = 26;  // CORDIC x/y width
  localparam int unsigned ZW     = 34;  // CORDIC angle width
  localparam int unsigned VW     = 40;  // scaled value width
  localparam int unsigned AtanN  = 30;

  localparam logic signed [XyW-1:0] GainInv = 26'sd2547003;

  typedef enum logic [IdxW-1:0] {
    REG_SAMPLE_COUNT = 2'd0,
    REG_MAX_LEVEL    = 2'd1,
    REG_MIN_LEVEL    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  // Arctangent of 2^-i as a 32-bit fraction of a turn.
  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sine_table_sample_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 12 remainder stages, 32 phase division stages, 1 fold,
//   CORDIC_STEPS rotations, multiply, offset add, output register.
// Throughput: one item per cycle; the whole pipeline holds when the output
//   register is full and not taken.
// Reset: clears all valid bits and loads count 256, max 4095, min 0.
// ----------------------------------------------------------------------------
// sine_table_sample_core
// One entry of an offset sine table: index mod count, phase by long
// division, CORDIC sine, scale, offset, round and saturate.
// ----------------------------------------------------------------------------
module sine_table_sample_core #(
  parameter int unsigned MAX_SAMPLES  = 4096,
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [15:0]                s_axis_tdata,  // [11:0] sample_index
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [11:0] level
  input  wire logic                       cfg_we_i,
  input  wire logic [stsc_pkg::IdxW-1:0]  cfg_idx_i,
  input  wire logic [stsc_pkg::CfgW-1:0]  cfg_data_i
);
  import stsc_pkg::*;

  localparam int unsigned ModN  = LvlW;
  localparam int unsigned PhN   = 32;
  localparam int unsigned FoldI = ModN + PhN;
  localparam int unsigned CorI  = FoldI + 1;
  localparam int unsigned MulI  = CorI + CORDIC_STEPS;
  localparam int unsigned AddI  = MulI + 1;
  localparam int unsigned NV    = AddI + 1;

  // Configuration registers
  logic [CntW-1:0] count_q;
  logic [LvlW-1:0] max_q, min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 13'd256;
      max_q   <= 12'd4095;
      min_q   <= 12'd0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SAMPLE_COUNT: count_q <= cfg_data_i;
        REG_MAX_LEVEL:    max_q   <= cfg_data_i[LvlW-1:0];
        REG_MIN_LEVEL:    min_q   <= cfg_data_i[LvlW-1:0];
        default: ;
      endcase
    end
  end

  // Effective divisor: zero counts as one, clamp at MAX_SAMPLES.
  logic [CntW-1:0] cnt;
  logic [CntW:0]   cnt_x;
  always_comb begin
    if (count_q == '0) begin
      cnt = 13'd1;
    end else if ({19'd0, count_q} > MAX_SAMPLES) begin
      cnt = MAX_SAMPLES[CntW-1:0];
    end else begin
      cnt = count_q;
    end
    cnt_x = {1'b0, cnt};
  end

  // Half span, truncated toward zero.
  logic signed [CntW-1:0] diff, half_span;
  always_comb begin
    diff = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
    if (diff < 0) begin
      half_span = -((-diff) >>> 1);
    end else begin
      half_span = diff >>> 1;
    end
  end

  // Global advance: hold everything while the output item waits.
  logic en;
  logic out_vld_q;
  logic [LvlW-1:0] out_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [NV-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NV-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[NV-1];
    end
  end

  // Index remainder: one bit per stage, restoring.
  logic [CntW-1:0] mrem_q [ModN];
  logic [LvlW-1:0] midx_q [ModN];
  for (genvar k = 0; k < ModN; k++) begin : g_mod
    logic [CntW-1:0] rin;
    logic [LvlW-1:0] iin;
    logic [CntW:0]   t;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign iin = s_axis_tdata[LvlW-1:0];
    end else begin : g_next
      assign rin = mrem_q[k-1];
      assign iin = midx_q[k-1];
    end
    assign t = {rin, iin[ModN-1-k]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        mrem_q[k] <= (t >= cnt_x) ? 13'(t - cnt_x) : t[CntW-1:0];
        midx_q[k] <= iin;
      end
    end
  end

  // Phase = (rem << 32) / count, one quotient bit per stage.
  logic [CntW-1:0] prem_q [PhN];
  logic [31:0]     pq_q   [PhN];
  for (genvar k = 0; k < PhN; k++) begin : g_ph
    logic [CntW-1:0] rin;
    logic [31:0]     qin;
    logic [CntW:0]   t;
    logic            b;
    if (k == 0) begin : g_first
      assign rin = mrem_q[ModN-1];
      assign qin = '0;
    end else begin : g_next
      assign rin = prem_q[k-1];
      assign qin = pq_q[k-1];
    end
    assign t = {rin, 1'b0};
    assign b = (t >= cnt_x);
    always_ff @(posedge clk_i) begin
      if (en) begin
        prem_q[k] <= b ? 13'(t - cnt_x) : t[CntW-1:0];
        pq_q[k]   <= {qin[30:0], b};
      end
    end
  end

  // Fold the phase into the right half plane.
  logic [31:0]          ph, fph;
  logic signed [ZW-1:0] fz_q;
  always_comb begin
    ph  = pq_q[PhN-1];
    fph = ((ph - 32'h4000_0000) < 32'h8000_0000) ? (32'h8000_0000 - ph) : ph;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fz_q <= ZW'($signed(fph));
    end
  end

  // CORDIC rotation, one step per stage.
  logic signed [XyW-1:0] cx_q [CORDIC_STEPS];
  logic signed [XyW-1:0] cy_q [CORDIC_STEPS];
  logic signed [ZW-1:0]  cz_q [CORDIC_STEPS];
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
    logic signed [XyW-1:0] xin, yin;
    logic signed [ZW-1:0]  zin, at;
    if (k == 0) begin : g_first
      assign xin = GainInv;
      assign yin = '0;
      assign zin = fz_q;
    end else begin : g_next
      assign xin = cx_q[k-1];
      assign yin = cy_q[k-1];
      assign zin = cz_q[k-1];
    end
    assign at = $signed({2'b00, atan_turns(k)});
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (zin >= 0) begin
          cx_q[k] <= xin - (yin >>> k);
          cy_q[k] <= yin + (xin >>> k);
          cz_q[k] <= zin - at;
        end else begin
          cx_q[k] <= xin + (yin >>> k);
          cy_q[k] <= yin - (xin >>> k);
          cz_q[k] <= zin + at;
        end
      end
    end
  end

  // Scale by the half span, then add the offset.
  logic signed [XyW:0]  s_off;
  logic signed [VW-1:0] prod_q, v_q;
  assign s_off = (XyW+1)'(cy_q[CORDIC_STEPS-1]) + 27'sd4194304;
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= VW'(s_off) * VW'(half_span);
      v_q    <= prod_q + $signed({6'd0, min_q, 22'd0});
    end
  end

  // Round half up on the non-negative side; negative values saturate to zero, values above 4095 to 4095.
  logic [VW-1:0]   rsum;
  logic [17:0]     r;
  logic [LvlW-1:0] lvl;
  always_comb begin
    rsum = v_q + 40'd2097152;
    r    = rsum[VW-1:FracW];
    if (v_q[VW-1]) begin
      lvl = '0;
    end else if (r > 18'd4095) begin
      lvl = 12'd4095;
    end else begin
      lvl = r[LvlW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= lvl;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_q};

endmodule
`default_nettype wire

// ===== hw/rtl/stsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks of the sine table sample core, bound to the top level.
// ----------------------------------------------------------------------------
module stsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // Held output item keeps its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // Input side stalls only behind a waiting output item.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // Padding bits above the level stay zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
    else $error("output padding not zero");

endmodule

bind sine_table_sample_core stsc_checker u_stsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
